[hdl/arxsc_pkg.sv]
// Shared types, constants and mixing functions for the ARX byte stream cipher.
// Used by every module under hdl; no dependencies of its own.
package arxsc_pkg;

    localparam int WORD_W      = 32;
    localparam int STATE_WORDS = 16;
    localparam int PRE_ROUNDS  = 6;
    localparam int POST_ROUNDS = 2;
    // each round takes two steps: xor/add half, then the feedback adds
    localparam int MIX_STEPS   = 2 * (PRE_ROUNDS + POST_ROUNDS);
    localparam int STEP_W      = $clog2(MIX_STEPS);
    localparam int SWAP_STEP   = 2 * PRE_ROUNDS - 1;
    localparam int POS_W       = 7;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [POS_W-1:0] BLOCK_BYTES = POS_W'(64);
    localparam logic [31:0] CONST_WORD_10 = 32'h2d343653;
    localparam logic [31:0] CONST_WORD_11 = 32'h2b505243;
    localparam logic [31:0] NIBBLE_MASK   = 32'h0f0f0f0f;

    typedef logic [WORD_W-1:0] word_t;
    typedef word_t [STATE_WORDS-1:0] state_t;

    typedef enum logic {
        REQ_INIT = 1'b0,
        REQ_DATA = 1'b1
    } req_kind_t;

    typedef enum logic [2:0] {
        CFG_KEY0   = 3'd0,
        CFG_KEY1   = 3'd1,
        CFG_KEY2   = 3'd2,
        CFG_KEY3   = 3'd3,
        CFG_IV     = 3'd4,
        CFG_NONCE0 = 3'd5,
        CFG_NONCE1 = 3'd6,
        CFG_CTR    = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        req_kind_t  kind;
        logic [7:0] data;
        logic       last;
    } item_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mix_stat_t;

    function automatic word_t rotl32(input word_t x, input int unsigned amt);
        return (x << amt) | (x >> (WORD_W - amt));
    endfunction

    // xor step and the first three adds of each group
    function automatic state_t mix_half_a(input state_t s);
        state_t n;
        word_t  x0, x1, x2, x3;
        n  = s;
        x0 = s[0] ^ s[15] ^ s[14] ^ s[13];
        x1 = s[1] ^ s[12] ^ s[11] ^ s[10];
        x2 = s[2] ^ s[9] ^ s[8] ^ s[7];
        x3 = s[3] ^ s[6] ^ s[5] ^ s[4];
        n[0]  = x0 + rotl32(s[5], 3);
        n[5]  = s[5] + rotl32(s[10], 5);
        n[10] = s[10] + rotl32(s[15], 7);
        n[4]  = s[4] + rotl32(s[9], 11);
        n[9]  = s[9] + rotl32(s[14], 13);
        n[14] = s[14] + rotl32(x3, 17);
        n[3]  = x3;
        n[8]  = s[8] + rotl32(s[13], 19);
        n[13] = s[13] + rotl32(x2, 23);
        n[2]  = x2 + rotl32(s[7], 29);
        n[12] = s[12] + rotl32(x1, 31);
        n[1]  = x1 + rotl32(s[6], 1);
        n[6]  = s[6] + rotl32(s[11], 2);
        return n;
    endfunction

    // feedback adds that close each group
    function automatic state_t mix_half_b(input state_t s);
        state_t n;
        n     = s;
        n[15] = s[15] + s[0];
        n[3]  = s[3] + s[4];
        n[7]  = s[7] + s[8];
        n[11] = s[11] + s[12];
        return n;
    endfunction

    function automatic state_t nibble_swap(input state_t s);
        state_t n;
        for (int i = 0; i < STATE_WORDS; i++) begin
            n[i] = ((s[i] & NIBBLE_MASK) << 4) | ((s[i] >> 4) & NIBBLE_MASK);
        end
        return n;
    endfunction

endpackage

[hdl/arxsc_front.sv]
// Input side: takes stream transactions and queues them as classified items.
// Depends on arxsc_pkg.
module arxsc_front import arxsc_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_in
    input  logic       s_tuser,   // [0] req_type
    input  logic       s_tlast,
    output logic       q_valid,
    output item_t      q_item,
    input  logic       q_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    item_t            mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push;
    item_t            in_item;

    assign s_tready = (count_reg != FULL_CNT);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != '0);
    assign q_item   = mem_reg[rd_ptr_reg];

    always_comb begin
        in_item.kind = req_kind_t'(s_tuser);
        in_item.data = s_tdata;
        in_item.last = s_tlast;
    end

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop) begin
            count_next = count_reg + 1'b1;
        end else if (q_pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

[hdl/arxsc_mixer.sv]
// Iterative keystream update: eight mixing rounds, two steps each, with the
// nibble swap after the sixth round. Depends on arxsc_pkg.
module arxsc_mixer import arxsc_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      start,
    input  state_t    start_state,
    output mix_stat_t stat,
    output state_t    result
);

    state_t            st_reg, st_next;
    state_t            half_a, half_b;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;
    logic              last_step;

    assign last_step   = busy_reg && (step_reg == STEP_W'(MIX_STEPS - 1));
    assign stat.busy   = busy_reg;
    assign stat.done   = done_reg;
    assign result      = st_reg;

    always_comb begin
        half_a = mix_half_a(st_reg);
        half_b = mix_half_b(st_reg);
        if (!step_reg[0]) begin
            st_next = half_a;
        end else if (step_reg == STEP_W'(SWAP_STEP)) begin
            st_next = nibble_swap(half_b);
        end else begin
            st_next = half_b;
        end
    end

    // out of reset, start on the all-zero state so the first block is ready
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= '0;
            step_reg <= '0;
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end else begin
            // a restart on the last step drops the old run's completion
            done_reg <= last_step && !start;
            if (start) begin
                st_reg   <= start_state;
                step_reg <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                st_reg   <= st_next;
                step_reg <= step_reg + 1'b1;
                if (last_step) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

endmodule

[hdl/arxsc_back.sv]
// Execution side: keeps the current and precomputed keystream blocks, the stream
// position and the output register. Depends on arxsc_pkg.
module arxsc_back import arxsc_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       q_valid,
    input  item_t      q_item,
    output logic       q_pop,
    input  state_t     load_words,
    input  mix_stat_t  mix_stat,
    input  state_t     mix_result,
    output logic       mix_start,
    output state_t     mix_state_in,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] data_out
    output logic       m_tlast
);

    state_t           cur_reg;
    state_t           nxt_reg;
    logic             nxt_valid_reg;
    logic             chain_reg;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             m_valid_reg;
    logic [7:0]       m_data_reg;
    logic             m_last_reg;

    logic       out_free;
    logic       is_data;
    logic       pop_init;
    logic       pop_data;
    logic       take_next;
    word_t      cur_word;
    logic [7:0] ks_byte;

    assign out_free  = !m_valid_reg || m_tready;
    assign is_data   = (q_item.kind == REQ_DATA);
    assign pop_init  = q_valid && !is_data;
    assign pop_data  = q_valid && is_data && out_free && (!pos_reg[POS_W-1] || nxt_valid_reg);
    assign take_next = pop_data && pos_reg[POS_W-1];
    assign q_pop     = pop_init || pop_data;

    // an init restarts the mixer; a finished init update is fed straight back
    assign mix_start = pop_init || take_next || (mix_stat.done && chain_reg);

    always_comb begin
        if (pop_init) begin
            mix_state_in = load_words;
        end else if (take_next) begin
            mix_state_in = nxt_reg;
        end else begin
            mix_state_in = mix_result;
        end
    end

    always_comb begin
        cur_word = cur_reg[pos_reg[5:2]];
        if (pos_reg[POS_W-1]) begin
            ks_byte = nxt_reg[0][7:0];
        end else begin
            ks_byte = 8'(cur_word >> {pos_reg[1:0], 3'b000});
        end
    end

    always_comb begin
        pos_next = pos_reg;
        if (pop_init) begin
            pos_next = BLOCK_BYTES;
        end else if (pop_data) begin
            if (q_item.last) begin
                pos_next = BLOCK_BYTES;
            end else if (take_next) begin
                pos_next = POS_W'(1);
            end else begin
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nxt_valid_reg <= 1'b0;
            chain_reg     <= 1'b0;
            pos_reg       <= BLOCK_BYTES;
            m_valid_reg   <= 1'b0;
        end else begin
            pos_reg <= pos_next;
            if (pop_init) begin
                chain_reg     <= 1'b1;
                nxt_valid_reg <= 1'b0;
            end else if (mix_stat.done) begin
                if (chain_reg) begin
                    chain_reg <= 1'b0;
                end else begin
                    nxt_valid_reg <= 1'b1;
                end
            end else if (take_next) begin
                nxt_valid_reg <= 1'b0;
            end
            if (pop_data) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!pop_init && mix_stat.done) begin
            if (chain_reg) begin
                cur_reg <= mix_result;
            end else begin
                nxt_reg <= mix_result;
            end
        end else if (take_next) begin
            cur_reg <= nxt_reg;
        end
        if (pop_data) begin
            m_data_reg <= q_item.data ^ ks_byte;
            m_last_reg <= q_item.last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    a_done_free_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        mix_stat.done |-> !nxt_valid_reg)
        else $error("mixer finished while the next block was still held");

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        nxt_valid_reg |-> !mix_stat.busy)
        else $error("next block marked ready while the mixer runs");

    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg[POS_W-1] |-> (pos_reg[POS_W-2:0] == '0))
        else $error("stream position beyond one block");

    a_fresh_block: assert property (@(posedge aclk) disable iff (!aresetn)
        take_next |=> (pos_reg == POS_W'(1) || pos_reg == BLOCK_BYTES))
        else $error("wrong position after switching to a new block");

endmodule

[hdl/arx_byte_stream_cipher_top.sv]
// A data byte goes from s_ through the input queue and the output register to m_ when a block is on hand.
// Throughput: 1 byte per cycle while m_tready is high and a block is on hand; a keystream update takes
// 8 mixer rounds, 2 steps each, and then a hand-over through the done flag into the next-block register.
// It runs in the background, so only a message that ends before the next block is ready stalls the one after it.
// An init transaction costs two chained updates: the next byte goes out only after both have finished
// and the second block has been handed over.
// Reset: aresetn synchronous, active low; control and configuration registers clear, and the mixer then
// starts on the all-zero state, so the first block becomes ready without an init.
module arx_byte_stream_cipher_top import arxsc_pkg::*; #(
    parameter int QDEPTH = QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_in
    input  logic        s_tuser,   // [0] req_type
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] data_out
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    logic [63:0] key0_reg, key1_reg, key2_reg, key3_reg;
    logic [63:0] iv_reg, nonce0_reg;
    logic [31:0] nonce1_reg, ctr_reg;
    logic        cfg_write;
    state_t      load_words;

    logic      q_valid;
    item_t     q_item;
    logic      q_pop;
    mix_stat_t mix_stat;
    state_t    mix_result;
    logic      mix_start;
    state_t    mix_state_in;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key0_reg   <= '0;
            key1_reg   <= '0;
            key2_reg   <= '0;
            key3_reg   <= '0;
            iv_reg     <= '0;
            nonce0_reg <= '0;
            nonce1_reg <= '0;
            ctr_reg    <= '0;
        end else if (cfg_write) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_KEY0:   key0_reg   <= cfg_data;
                CFG_KEY1:   key1_reg   <= cfg_data;
                CFG_KEY2:   key2_reg   <= cfg_data;
                CFG_KEY3:   key3_reg   <= cfg_data;
                CFG_IV:     iv_reg     <= cfg_data;
                CFG_NONCE0: nonce0_reg <= cfg_data;
                CFG_NONCE1: nonce1_reg <= cfg_data[31:0];
                CFG_CTR:    ctr_reg    <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // counter goes in big-endian
    always_comb begin
        load_words[0]  = key0_reg[31:0];
        load_words[1]  = key0_reg[63:32];
        load_words[2]  = key1_reg[31:0];
        load_words[3]  = key1_reg[63:32];
        load_words[4]  = key2_reg[31:0];
        load_words[5]  = key2_reg[63:32];
        load_words[6]  = key3_reg[31:0];
        load_words[7]  = key3_reg[63:32];
        load_words[8]  = iv_reg[31:0];
        load_words[9]  = iv_reg[63:32];
        load_words[10] = CONST_WORD_10;
        load_words[11] = CONST_WORD_11;
        load_words[12] = nonce0_reg[31:0];
        load_words[13] = nonce0_reg[63:32];
        load_words[14] = nonce1_reg;
        load_words[15] = {ctr_reg[7:0], ctr_reg[15:8], ctr_reg[23:16], ctr_reg[31:24]};
    end

    arxsc_front #(
        .DEPTH(QDEPTH)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    arxsc_mixer u_mixer (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (mix_start),
        .start_state (mix_state_in),
        .stat        (mix_stat),
        .result      (mix_result)
    );

    arxsc_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop),
        .load_words   (load_words),
        .mix_stat     (mix_stat),
        .mix_result   (mix_result),
        .mix_start    (mix_start),
        .mix_state_in (mix_state_in),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast)
    );

endmodule
